### src/lla_pkg.sv
// Package for the lookaside line allocator: field widths, codes and state types.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package lla_pkg;

	localparam int KEY_W      = 16;
	localparam int LINE_OUT_W = 8;
	localparam int STAT_W     = 3;
	localparam int DEF_LINES  = 16;

	localparam logic [KEY_W-1:0] KERNEL_KEY = 16'd1;

	typedef enum logic [STAT_W-1:0] {
		ST_HIT      = 3'd0,
		ST_ALLOC    = 3'd1,
		ST_INVAL    = 3'd2,
		ST_INV_MISS = 3'd3,
		ST_KERN_ERR = 3'd4
	} status_t;

	typedef enum logic {
		KIND_STORE = 1'b0,
		KIND_INVAL = 1'b1
	} kind_t;

	typedef enum logic {
		BUF_MODE = 1'b0,
		BUF_PERM = 1'b1
	} buf_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_RES
	} state_t;

endpackage

### src/lla_if.sv
// Request and response channel interfaces of the lookaside line allocator.
// Depends on lla_pkg.
`timescale 1ns / 1ps

interface lla_req_if import lla_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic             which_buffer;
	logic [KEY_W-1:0] key;

	modport source (output valid, kind, which_buffer, key, input ready);
	modport sink   (input valid, kind, which_buffer, key, output ready);
endinterface

interface lla_rsp_if import lla_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [LINE_OUT_W-1:0] line;
	logic                  writes_line;
	logic [STAT_W-1:0]     status;

	modport source (output valid, line, writes_line, status, input ready);
	modport sink   (input valid, line, writes_line, status, output ready);
endinterface

### src/lla_tag_mem.sv
// Tag memory: one row per buffer holding all line tags, registered read port.
// Depends on lla_pkg.
`timescale 1ns / 1ps

module lla_tag_mem import lla_pkg::*; #(
	parameter int LINES = DEF_LINES
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic                          rd_addr,
	output logic [LINES-2:0][KEY_W-1:0]   rd_row,
	input  logic                          wr_en,
	input  logic                          wr_addr,
	input  logic [LINES-2:0][KEY_W-1:0]   wr_row
);

	logic [LINES-2:0][KEY_W-1:0] mem_q [2];
	logic [LINES-2:0][KEY_W-1:0] rd_row_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem_q[rd_addr];
		end
	end

	assign rd_row = rd_row_q;

endmodule

### src/lla_match.sv
// Tag compare stage and lowest-line priority encoder.
// Depends on lla_pkg.
`timescale 1ns / 1ps

module lla_match import lla_pkg::*; #(
	parameter int LINES = DEF_LINES
) (
	input  logic                          clk,
	input  logic                          cmp_en,
	input  logic [LINES-2:0][KEY_W-1:0]   tags,
	input  logic [LINES-2:0]              vld,
	input  logic [KEY_W-1:0]              key,
	output logic [LINES-2:0]              match,
	output logic                          hit,
	output logic [$clog2(LINES)-1:0]      hit_line
);

	localparam int ENTRIES = LINES - 1;
	localparam int LINE_W  = $clog2(LINES);

	logic [ENTRIES-1:0] match_q;
	logic [ENTRIES-1:0] eq;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			eq[i] = vld[i] && (tags[i] == key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_q <= eq;
		end
	end

	// lowest matching line wins
	always_comb begin
		hit_line = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_line = LINE_W'(i + 1);
			end
		end
	end

	assign hit   = |match_q;
	assign match = match_q;

endmodule

### src/lookaside_line_allocator.sv
// Lookaside line allocator: tag tables of the mode and permission buffers.
// Each request passes the tag row read, the compare register, then write-back with the
// response register; a new request is taken only once the last one's response is
// registered, and an untaken response blocks input.
// Reset clears valid bits and sets both round-robin pointers to line 1; tags are not cleared.
`timescale 1ns / 1ps

module lookaside_line_allocator import lla_pkg::*; #(
	parameter int LINES = DEF_LINES
) (
	input  logic       clk,
	input  logic       arst_n,
	lla_req_if.sink    req,
	lla_rsp_if.source  rsp
);

	localparam int ENTRIES = LINES - 1;
	localparam int LINE_W  = $clog2(LINES);
	localparam int ENT_W   = $clog2(ENTRIES);

	state_t state_q, state_d;

	logic             kind_s1;
	logic             buf_s1;
	logic [KEY_W-1:0] key_s1;

	logic [ENTRIES-1:0] vld_q [2];
	logic [LINE_W-1:0]  ptr_q [2];

	logic                  rsp_valid_q;
	logic [LINE_OUT_W-1:0] rsp_line_q;
	logic                  rsp_wl_q;
	status_t               rsp_status_q;

	logic                        acc;
	logic                        cmp_en;
	logic                        res_go;
	logic [ENTRIES-1:0][KEY_W-1:0] rd_row;
	logic [ENTRIES-1:0][KEY_W-1:0] wr_row;
	logic [ENTRIES-1:0]          match;
	logic                        hit;
	logic [LINE_W-1:0]           hit_line;

	logic              kern;
	logic [LINE_W-1:0] ptr_cur;
	logic [LINE_W-1:0] alloc_line;
	logic [LINE_W-1:0] ptr_nxt;
	logic [ENT_W-1:0]  alloc_idx;
	logic [ENT_W-1:0]  hit_idx;
	logic              do_alloc;
	logic              do_clear;
	logic [LINE_W-1:0] res_line;
	logic              res_wl;
	status_t           res_status;

	assign acc = req.valid && req.ready;

	lla_tag_mem #(.LINES(LINES)) u_mem (
		.clk     (clk),
		.rd_en   (acc),
		.rd_addr (req.which_buffer),
		.rd_row  (rd_row),
		.wr_en   (do_alloc),
		.wr_addr (buf_s1),
		.wr_row  (wr_row)
	);

	lla_match #(.LINES(LINES)) u_match (
		.clk      (clk),
		.cmp_en   (cmp_en),
		.tags     (rd_row),
		.vld      (vld_q[buf_s1]),
		.key      (key_s1),
		.match    (match),
		.hit      (hit),
		.hit_line (hit_line)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_RES;
			end
			S_RES: begin
				if (res_go) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		cmp_en    = (state_q == S_CMP);
		res_go    = (state_q == S_RES) && (!rsp_valid_q || rsp.ready);
	end

	always_comb begin
		kern       = (buf_t'(buf_s1) == BUF_MODE) && (key_s1 == KERNEL_KEY);
		ptr_cur    = ptr_q[buf_s1];
		alloc_line = (ptr_cur == '0) ? LINE_W'(1) : ptr_cur;
		ptr_nxt    = (alloc_line == LINE_W'(LINES - 1)) ? LINE_W'(1) : alloc_line + LINE_W'(1);
		alloc_idx  = ENT_W'(alloc_line - LINE_W'(1));
		hit_idx    = ENT_W'(hit_line - LINE_W'(1));
		wr_row            = rd_row;
		wr_row[alloc_idx] = key_s1;

		do_alloc   = 1'b0;
		do_clear   = 1'b0;
		res_line   = '0;
		res_wl     = 1'b0;
		res_status = ST_HIT;
		priority if (kern) begin
			res_wl     = (kind_t'(kind_s1) == KIND_STORE);
			res_status = (kind_t'(kind_s1) == KIND_STORE) ? ST_HIT : ST_KERN_ERR;
		end else if (kind_t'(kind_s1) == KIND_STORE) begin
			res_wl = 1'b1;
			if (hit) begin
				res_line   = hit_line;
				res_status = ST_HIT;
			end else begin
				res_line   = alloc_line;
				res_status = ST_ALLOC;
				do_alloc   = res_go;
			end
		end else begin
			if (hit) begin
				res_line   = hit_line;
				res_wl     = 1'b1;
				res_status = ST_INVAL;
				do_clear   = res_go;
			end else begin
				res_status = ST_INV_MISS;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			vld_q[0]    <= '0;
			vld_q[1]    <= '0;
			ptr_q[0]    <= LINE_W'(1);
			ptr_q[1]    <= LINE_W'(1);
		end else begin
			state_q <= state_d;
			if (res_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (do_alloc) begin
				vld_q[buf_s1][alloc_idx] <= 1'b1;
				ptr_q[buf_s1]            <= ptr_nxt;
			end
			if (do_clear) begin
				vld_q[buf_s1][hit_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_s1 <= req.kind;
			buf_s1  <= req.which_buffer;
			key_s1  <= req.key;
		end
		if (res_go) begin
			rsp_line_q   <= LINE_OUT_W'(res_line);
			rsp_wl_q     <= res_wl;
			rsp_status_q <= res_status;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.line        = rsp_line_q;
	assign rsp.writes_line = rsp_wl_q;
	assign rsp.status      = rsp_status_q;

`ifndef NO_ASSERTIONS
	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q == S_CMP))
		else $error("accepted item did not enter compare");

	a_ptr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(ptr_q[0] != '0) && (ptr_q[1] != '0))
		else $error("round-robin pointer is zero");

	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RES) |-> $onehot0(match))
		else $error("several lines hold the same tag");

	a_hit_keeps_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_go && hit) |=> ($stable(ptr_q[0]) && $stable(ptr_q[1])))
		else $error("pointer moved on a hit");
`endif

endmodule
